FILE: rtl/bns_pkg.sv
// Shared types and codes for the bounded neighbour set.
`default_nettype none

package bns_pkg;

    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_DELETE = 2'd1;
    localparam opcode_t OP_QUERY  = 2'd2;

    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_PRESENT = 2'd1;
    localparam status_t ST_ABSENT  = 2'd2;
    localparam status_t ST_REJECT  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming request
        logic match;  // register the slot compare
        logic apply;  // update the set and load the result register
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/bns_req_if.sv
// Request channel: opcode and vertex index with valid/ready.
`default_nettype none

interface bns_req_if
    import bns_pkg::*;
#(
    parameter int INDEX_BITS = 20
);
    logic                   valid;
    logic                   ready;
    opcode_t                opcode;
    logic signed [INDEX_BITS:0] vertex_index;

    modport source (output valid, output opcode, output vertex_index, input ready);
    modport sink   (input valid, input opcode, input vertex_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/bns_rsp_if.sv
// Result channel: status, found flag and entry count with valid/ready.
`default_nettype none

interface bns_rsp_if
    import bns_pkg::*;
;
    logic    valid;
    logic    ready;
    status_t status;
    logic    found;
    count_t  entry_count;

    modport source (output valid, output status, output found, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input found, input entry_count,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/bounded_neighbor_set.sv
// Top level of the bounded neighbour set: controller, datapath and channel wiring.
//
//  Channel   Dir  Handshake     Payload
//  request   in   valid/ready   opcode[1:0], vertex_index[INDEX_BITS:0] (signed)
//  result    out  valid/ready   status[1:0], found, entry_count[4:0]
//
// Each request passes through capture, a registered compare of the index
// against every held slot, then the update and result load.
// Reset clears the count, so the set starts empty; slot contents need no reset.
// A new request is taken while the previous result waits in its register;
// the update stalls only when that register is still full.
`default_nettype none

module bounded_neighbor_set
    import bns_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int INDEX_BITS = 20
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bns_req_if.sink     request,
    bns_rsp_if.source   result
);

    cmd_t cmd;

    // Sequence each request through capture, compare and update.
    bns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // Hold the slots and the count; produce the result payload.
    bns_datapath #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (request.opcode),
        .vertex_index (request.vertex_index),
        .status       (result.status),
        .found        (result.found),
        .entry_count  (result.entry_count)
    );

endmodule

`default_nettype wire

FILE: rtl/bns_ctrl.sv
// Controller: sequences capture, compare and update for each request.
`default_nettype none

module bns_ctrl
    import bns_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       apply_ok;

    // Result register is free when empty or being drained this cycle.
    assign apply_ok = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.load  = (state_reg == S_IDLE) && in_valid;
    assign cmd.match = (state_reg == S_MATCH);
    assign cmd.apply = apply_ok;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bns_datapath.sv
// Datapath: slot row, parallel compare, insert/delete update and result register.
`default_nettype none

module bns_datapath
    import bns_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int INDEX_BITS = 20
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    input  wire opcode_t                opcode,
    input  wire logic [INDEX_BITS:0]    vertex_index,
    output status_t                     status,
    output logic                        found,
    output count_t                      entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    opcode_t                op_reg;
    logic                   neg_reg;
    logic [INDEX_BITS-1:0]  val_reg;

    logic [INDEX_BITS-1:0]  slot_reg  [CAPACITY];
    logic [INDEX_BITS-1:0]  slot_next [CAPACITY];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic [CAPACITY-1:0]    used;
    logic [CAPACITY-1:0]    match_reg;
    logic [CAPACITY-1:0]    match_next;
    logic [CAPACITY-1:0]    shift_mask;

    logic                   hit;
    logic                   full;
    logic                   do_insert;
    logic                   do_delete;
    status_t                status_next;
    logic                   found_next;

    status_t                status_reg;
    logic                   found_reg;
    count_t                 count_out_reg;

    // Entries are packed at the front, so occupancy follows from the count.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            used[i]       = (CNT_W'(i) < count_reg);
            match_next[i] = used[i] && (slot_reg[i] == val_reg);
        end
    end

    // Every slot at or after the match takes its successor on delete.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            shift_mask[i] = 1'b0;
            for (int j = 0; j < CAPACITY; j++)
            begin
                if (j <= i)
                begin
                    shift_mask[i] = shift_mask[i] | match_reg[j];
                end
            end
        end
    end

    assign hit  = |match_reg;
    assign full = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        do_insert   = 1'b0;
        do_delete   = 1'b0;
        status_next = ST_DONE;
        found_next  = 1'b0;
        case (op_reg)
            OP_INSERT:
            begin
                if (neg_reg)
                begin
                    status_next = ST_REJECT;
                end
                else if (hit)
                begin
                    status_next = ST_PRESENT;
                end
                else if (full)
                begin
                    status_next = ST_REJECT;
                end
                else
                begin
                    do_insert = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (neg_reg)
                begin
                    status_next = ST_REJECT;
                end
                else if (!hit)
                begin
                    status_next = ST_ABSENT;
                end
                else
                begin
                    do_delete = 1'b1;
                end
            end
            OP_QUERY:
            begin
                found_next = !neg_reg && hit;
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_delete)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (do_insert && (CNT_W'(i) == count_reg))
            begin
                slot_next[i] = val_reg;
            end
            else if (do_delete && shift_mask[i])
            begin
                if (i < CAPACITY - 1)
                begin
                    slot_next[i] = slot_reg[(i + 1) % CAPACITY];
                end
                else
                begin
                    slot_next[i] = '0;
                end
            end
        end
    end

    // Request capture and result payload hold no control state.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            neg_reg <= vertex_index[INDEX_BITS];
            val_reg <= vertex_index[INDEX_BITS-1:0];
        end
        if (cmd.match)
        begin
            match_reg <= match_next;
        end
        if (cmd.apply)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            count_out_reg <= COUNT_W'(count_next);
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.apply)
        begin
            count_reg <= count_next;
        end
    end

    assign status      = status_reg;
    assign found       = found_reg;
    assign entry_count = count_out_reg;

endmodule

`default_nettype wire
